FILE: rtl/core/fen_pkg.sv
// ============================================================================
// fen_pkg
// Shared types, constants and helper functions of the flood-echo node handler.
// ============================================================================
package fen_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_PORTS = 8;
	localparam int PORT_LIM  = (MAX_PORTS < 8) ? MAX_PORTS : 8;

	localparam int ID_W       = 6;
	localparam int PORT_W     = 3;
	localparam int CNT_W      = 4;
	localparam int PCNT_W     = 4;
	localparam int TBL_AW     = $clog2(MAX_NODES);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int QDEPTH     = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 1'b1;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

	typedef struct packed {
		logic              reached;
		logic [CNT_W-1:0]  count;
		logic              has_parent;
		logic [PORT_W-1:0] parent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              do_start;
		logic              do_arrival;
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] ap;
	} job_t;

	typedef struct packed {
		logic              send_valid;
		logic [PORT_W-1:0] out_port;
		logic [ID_W-1:0]   message_id;
		logic              all_reached;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]   own_id;
		logic [PCNT_W-1:0] port_count;
	} cfg_t;

	function automatic logic [PCNT_W-1:0] eff_ports(input logic [PCNT_W-1:0] pc);
		logic [PCNT_W-1:0] p;
		p = pc;
		if (int'(pc) > PORT_LIM) begin
			p = PCNT_W'(PORT_LIM);
		end
		return p;
	endfunction

	function automatic logic id_in_table(input logic [ID_W-1:0] id);
		return int'(id) < MAX_NODES;
	endfunction

endpackage

FILE: rtl/core/fen_if.sv
// ============================================================================
// fen_if
// Valid/ready channels of the flood-echo node handler: request items in,
// result items out.
// ============================================================================
interface fen_in_if;
	import fen_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [ID_W-1:0]   origin_id;
	logic [PORT_W-1:0] arrival_port;

	modport source (output valid, command, origin_id, arrival_port, input ready);
	modport sink (input valid, command, origin_id, arrival_port, output ready);
endinterface

interface fen_out_if;
	import fen_pkg::*;

	logic              valid;
	logic              ready;
	logic              send_valid;
	logic [PORT_W-1:0] out_port;
	logic [ID_W-1:0]   message_id;
	logic              all_reached;
	logic              last;

	modport source (output valid, send_valid, out_port, message_id, all_reached, last,
		input ready);
	modport sink (input valid, send_valid, out_port, message_id, all_reached, last,
		output ready);
endinterface

FILE: rtl/core/fen_ram.sv
// ============================================================================
// fen_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fen_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/fen_front.sv
// ============================================================================
// fen_front
// Accepts request items, tracks whether the node has started and turns each
// request into a job for the back end.
// ============================================================================
module fen_front (
	input  logic          clk,
	input  logic          arst_n,
	fen_in_if.sink        item,
	output logic          push_valid,
	input  logic          push_ready,
	output fen_pkg::job_t push_data
);
	import fen_pkg::*;

	logic started_q;

	assign item.ready = push_ready;
	assign push_valid = item.valid;

	always_comb begin
		push_data.do_start   = (item.command == CMD_START) || !started_q;
		push_data.do_arrival = (item.command == CMD_ARRIVE) && id_in_table(item.origin_id);
		push_data.id         = item.origin_id;
		push_data.ap         = item.arrival_port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (item.valid && push_ready) begin
			started_q <= 1'b1;
		end
	end

endmodule

FILE: rtl/core/fen_queue.sv
// ============================================================================
// fen_queue
// Short job queue between the front end and the back end.
// ============================================================================
module fen_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  fen_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output fen_pkg::job_t pop_data
);
	import fen_pkg::*;

	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	job_t             ent_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != QCW'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/fen_back.sv
// ============================================================================
// fen_back
// Executes jobs: updates the per-origin table and emits the fan-out, forward
// and echo results through an output register, one per cycle unless stalled.
// ============================================================================
module fen_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fen_pkg::cfg_t cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  fen_pkg::job_t pop_data,
	fen_out_if.source     result
);
	import fen_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_OWN_WR,
		B_ID_RD,
		B_ID_EVAL,
		B_START,
		B_FWD,
		B_ECHO
	} bstate_t;

	bstate_t           state_q;
	job_t              job_q;
	logic [PORT_W-1:0] idx_q;
	logic              fwd_any_q;
	logic [PORT_W-1:0] fwd_last_q;
	logic              echo_q;
	result_t           echo_res_q;
	logic              vld_q [MAX_NODES];
	logic              rd_vld_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [PCNT_W-1:0] p;
	logic              slot_free;
	logic [TBL_AW-1:0] own_addr;
	logic [TBL_AW-1:0] raddr;
	logic [TBL_AW-1:0] waddr;
	logic              we;
	entry_t            wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t            cur;
	entry_t            upd;
	logic              first;
	logic              fwd_any_d;
	logic [PORT_W-1:0] last_port;
	logic [PORT_W-1:0] fwd_last_d;
	logic              echo_d;
	result_t           echo_res_d;
	logic              start_end;
	logic              scan_end;
	logic              emit;
	result_t           emit_res;

	fen_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_NODES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign p         = eff_ports(cfg.port_count);
	assign slot_free = !out_valid_q || result.ready;
	assign own_addr  = TBL_AW'(cfg.own_id);
	assign pop_ready = (state_q == B_IDLE);
	assign cur       = rd_vld_q ? entry_t'(rdata) : '0;
	assign first     = !cur.reached;
	assign start_end = (PCNT_W'(idx_q) + PCNT_W'(1)) == p;
	assign scan_end  = start_end;

	always_comb begin
		upd = cur;
		if (cur.count != COUNT_MAX) begin
			upd.count = cur.count + 1'b1;
		end
		if (first) begin
			upd.reached    = 1'b1;
			upd.has_parent = 1'b1;
			upd.parent     = job_q.ap;
		end
		fwd_any_d  = first && ((p > PCNT_W'(1)) || ((p == PCNT_W'(1)) && (job_q.ap != '0)));
		last_port  = PORT_W'(p - PCNT_W'(1));
		fwd_last_d = (job_q.ap == last_port) ? last_port - 1'b1 : last_port;
		echo_d     = (upd.count == p);
		echo_res_d.send_valid  = upd.has_parent;
		echo_res_d.out_port    = upd.has_parent ? upd.parent : '0;
		echo_res_d.message_id  = job_q.id;
		echo_res_d.all_reached = !upd.has_parent;
		echo_res_d.last        = 1'b1;
	end

	always_comb begin
		raddr = TBL_AW'(job_q.id);
		waddr = TBL_AW'(job_q.id);
		we    = 1'b0;
		wdata = upd;
		case (state_q)
			B_IDLE: begin
				raddr = pop_data.do_start ? own_addr : TBL_AW'(pop_data.id);
			end
			B_OWN_WR: begin
				waddr         = own_addr;
				we            = id_in_table(cfg.own_id);
				wdata         = cur;
				wdata.reached = 1'b1;
			end
			B_ID_EVAL: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		emit_res = echo_res_q;
		case (state_q)
			B_START: begin
				emit                 = slot_free;
				emit_res.send_valid  = 1'b1;
				emit_res.out_port    = idx_q;
				emit_res.message_id  = cfg.own_id;
				emit_res.all_reached = 1'b0;
				emit_res.last        = start_end && !fwd_any_q && !echo_q;
			end
			B_FWD: begin
				emit                 = slot_free && (idx_q != job_q.ap);
				emit_res.send_valid  = 1'b1;
				emit_res.out_port    = idx_q;
				emit_res.message_id  = job_q.id;
				emit_res.all_reached = 1'b0;
				emit_res.last        = (idx_q == fwd_last_q) && !echo_q;
			end
			B_ECHO: begin
				emit = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		job_q      <= (state_q == B_IDLE) ? pop_data : job_q;
		rd_vld_q   <= vld_q[raddr];
		if (emit) begin
			res_q <= emit_res;
		end
		if (state_q == B_ID_EVAL) begin
			fwd_last_q <= fwd_last_d;
			echo_res_q <= echo_res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			fwd_any_q   <= 1'b0;
			echo_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
			case (state_q)
				B_IDLE: begin
					fwd_any_q <= 1'b0;
					echo_q    <= 1'b0;
					idx_q     <= '0;
					if (pop_valid) begin
						if (pop_data.do_start) begin
							state_q <= B_OWN_WR;
						end else if (pop_data.do_arrival) begin
							state_q <= B_ID_EVAL;
						end
					end
				end
				B_OWN_WR: begin
					if (job_q.do_arrival) begin
						state_q <= B_ID_RD;
					end else if (p != '0) begin
						state_q <= B_START;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_ID_RD: begin
					state_q <= B_ID_EVAL;
				end
				B_ID_EVAL: begin
					fwd_any_q <= fwd_any_d;
					echo_q    <= echo_d;
					if (job_q.do_start && (p != '0)) begin
						state_q <= B_START;
					end else if (fwd_any_d) begin
						state_q <= B_FWD;
					end else if (echo_d) begin
						state_q <= B_ECHO;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_START: begin
					if (slot_free) begin
						if (start_end) begin
							idx_q <= '0;
							if (fwd_any_q) begin
								state_q <= B_FWD;
							end else if (echo_q) begin
								state_q <= B_ECHO;
							end else begin
								state_q <= B_IDLE;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_FWD: begin
					if (slot_free || (idx_q == job_q.ap)) begin
						if (scan_end) begin
							idx_q   <= '0;
							state_q <= echo_q ? B_ECHO : B_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_ECHO: begin
					if (slot_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.send_valid  = res_q.send_valid;
	assign result.out_port    = res_q.out_port;
	assign result.message_id  = res_q.message_id;
	assign result.all_reached = res_q.all_reached;
	assign result.last        = res_q.last;

endmodule

FILE: rtl/core/flood_echo_node_handler.sv
// ============================================================================
// flood_echo_node_handler
// Node of a flood-with-echo connectivity discovery.
//
// Requests enter on the item channel (valid/ready): a start command or a
// message arrival with its origin id and arrival port. Each request yields
// zero or more results on the result channel (valid/ready): sends on a port,
// or an all-reached report, with last set on the final one of a request.
// The user must write configuration (own id, port count) through cfg_we,
// cfg_index and cfg_wdata while the block is idle; the block itself does
// not enforce this. A two-entry job queue decouples request intake from
// execution. Each job does a read-modify-write of the origin table, then
// emits one send per port for a fan-out, one send per port other than the
// arrival port for a forward and one result for the echo.
// Reset clears the started flag, the origin table valid bits and the
// queue; the table needs no clearing pass. When the result receiver stalls,
// the output register holds its result and the back end waits, and the
// queue fills and then drops item ready.
// ============================================================================
module flood_echo_node_handler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fen_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fen_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	fen_in_if.sink                             item,
	fen_out_if.source                          result
);
	import fen_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id     <= '0;
			cfg_q.port_count <= PCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ID: begin
					cfg_q.own_id <= cfg_wdata[ID_W-1:0];
				end
				CFG_PORT_COUNT: begin
					cfg_q.port_count <= cfg_wdata[PCNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fen_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	fen_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	fen_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.result   (result)
	);

endmodule

FILE: rtl/core/fen_checker.sv
// ============================================================================
// fen_checker
// Port-level checks of the result channel of the flood-echo node handler.
// ============================================================================
module fen_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_send_valid,
	input logic [fen_pkg::PORT_W-1:0]  res_out_port,
	input logic [fen_pkg::ID_W-1:0]    res_message_id,
	input logic                        res_all_reached,
	input logic                        res_last
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result valid dropped while stalled.");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_send_valid) && $stable(res_out_port)
			&& $stable(res_message_id) && $stable(res_all_reached) && $stable(res_last))
		else $error("Result payload changed while stalled.");

	a_report_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_all_reached |-> !res_send_valid && res_out_port == '0 && res_last)
		else $error("All-reached report is not a final non-send result on port zero.");

	a_nonsend_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_send_valid |-> res_all_reached)
		else $error("Result neither sends nor reports.");

endmodule

bind flood_echo_node_handler fen_checker u_fen_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_send_valid (result.send_valid),
	.res_out_port   (result.out_port),
	.res_message_id (result.message_id),
	.res_all_reached(result.all_reached),
	.res_last       (result.last)
);

FILE: tb/tb_top.sv
// ============================================================================
// tb_top: flood-echo node handler testbench
// Drives start and arrival requests into the node under several own-id and
// port-count settings, predicts most sends and all-reached reports from a
// behavioral copy of the node's origin table, and checks each result field
// against it. Both channels idle and stall at random.
// ============================================================================
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fen_pkg::*;

	localparam int SETTLE = 40;
	localparam int PHASE_ITEMS = 52;
	localparam int PHASE_PC [9] = '{2, 4, 8, 1, 47, 3, 0, 6, 5};

	typedef enum {ROW_REQ, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic                     cmd;
		logic [ID_W-1:0]          id;
		logic [PORT_W-1:0]        ap;
		logic [CFG_IDX_W-1:0]     sel;
		logic [CFG_DATA_W-1:0]    val;
		int                       typed_count;
		result_t                  typed_res;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fen_in_if  req_ch();
	fen_out_if res_ch();

	flood_echo_node_handler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (req_ch),
		.result    (res_ch)
	);

	logic              node_started;
	logic [ID_W-1:0]   own_id_reg;
	logic [PCNT_W-1:0] port_cnt_reg;
	entry_t            reach_tbl [MAX_NODES];

	result_t   reaction[$];
	result_t   awaited_results[$];
	plan_row_t directed_rows[$];

	int mismatches = 0;
	int checked = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_tick = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1500000;
		$display("flood_echo_node_handler: mismatch");
		$finish;
	end

	function automatic result_t make_result(logic sv, logic [PORT_W-1:0] port,
		logic [ID_W-1:0] id, logic all, logic fin);
		result_t r;
		r.send_valid  = sv;
		r.out_port    = port;
		r.message_id  = id;
		r.all_reached = all;
		r.last        = fin;
		return r;
	endfunction

	function automatic int ports_in_use();
		int lim;
		lim = (MAX_PORTS < 8) ? MAX_PORTS : 8;
		return (int'(port_cnt_reg) > lim) ? lim : int'(port_cnt_reg);
	endfunction

	function automatic void announce_self();
		int p;
		p = ports_in_use();
		node_started = 1'b1;
		if (int'(own_id_reg) < MAX_NODES) begin
			reach_tbl[own_id_reg].reached = 1'b1;
		end
		for (int i = 0; i < p; i++) begin
			reaction.push_back(make_result(1'b1, PORT_W'(i), own_id_reg, 1'b0, 1'b0));
		end
	endfunction

	function automatic void node_react(logic cmd, logic [ID_W-1:0] id,
		logic [PORT_W-1:0] ap);
		int     p;
		entry_t e;
		p = ports_in_use();
		reaction.delete();
		if (cmd == CMD_START) begin
			announce_self();
		end else begin
			if (!node_started) begin
				announce_self();
			end
			if (int'(id) < MAX_NODES) begin
				e = reach_tbl[id];
				if (e.count != COUNT_MAX) begin
					e.count = e.count + 1'b1;
				end
				if (!e.reached) begin
					e.reached    = 1'b1;
					e.has_parent = 1'b1;
					e.parent     = ap;
					for (int i = 0; i < p; i++) begin
						if (i != int'(ap)) begin
							reaction.push_back(make_result(1'b1, PORT_W'(i), id, 1'b0, 1'b0));
						end
					end
				end
				if (int'(e.count) == p) begin
					if (e.has_parent) begin
						reaction.push_back(make_result(1'b1, e.parent, id, 1'b0, 1'b0));
					end else begin
						reaction.push_back(make_result(1'b0, '0, id, 1'b1, 1'b0));
					end
				end
				reach_tbl[id] = e;
			end
		end
		if (reaction.size() != 0) begin
			reaction[reaction.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic report_mismatch(string line);
		mismatches++;
		$display("%s", line);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
				checked, name, got, want));
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			checked++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result %0d: none pending (port %0d, id %0d)",
					checked, res_ch.out_port, res_ch.message_id));
			end else begin
				want = awaited_results.pop_front();
				check_field("send_valid", 8'(res_ch.send_valid), 8'(want.send_valid));
				check_field("out_port", 8'(res_ch.out_port), 8'(want.out_port));
				check_field("message_id", 8'(res_ch.message_id), 8'(want.message_id));
				check_field("all_reached", 8'(res_ch.all_reached), 8'(want.all_reached));
				check_field("last", 8'(res_ch.last), 8'(want.last));
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (rx_tick % 80 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			case (rx_mode)
				0: begin
					res_ch.ready <= 1'b1;
				end
				1: begin
					res_ch.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					res_ch.ready <= (rx_tick % 4 == 0);
				end
				default: begin
					res_ch.ready <= (rx_tick % 16 >= 11);
				end
			endcase
		end
	end

	task automatic push_request(logic cmd, logic [ID_W-1:0] id, logic [PORT_W-1:0] ap,
		bit typed, int typed_count, result_t typed_res);
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.origin_id    <= id;
		req_ch.arrival_port <= ap;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		node_react(cmd, id, ap);
		if (typed) begin
			if (typed_count == 1) begin
				awaited_results.push_back(typed_res);
			end
		end else begin
			foreach (reaction[i]) begin
				awaited_results.push_back(reaction[i]);
			end
		end
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		wait_drained();
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		if (sel == CFG_OWN_ID) begin
			own_id_reg = val[ID_W-1:0];
		end else begin
			port_cnt_reg = val[PCNT_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void plan_req(logic cmd, logic [ID_W-1:0] id, logic [PORT_W-1:0] ap);
		plan_row_t row;
		row = '{ROW_REQ, cmd, id, ap, '0, '0, 0, '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void plan_typed(logic cmd, logic [ID_W-1:0] id,
		logic [PORT_W-1:0] ap, int typed_count, result_t typed_res);
		plan_row_t row;
		row = '{ROW_TYPED, cmd, id, ap, '0, '0, typed_count, typed_res};
		directed_rows.push_back(row);
	endfunction

	function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{ROW_CFG, CMD_START, '0, '0, sel, val, 0, '0};
		directed_rows.push_back(row);
	endfunction

	initial begin
		int                p;
		int                base;
		int                pick;
		bit                calm;
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] ap;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_START;
		req_ch.origin_id    = '0;
		req_ch.arrival_port = '0;
		node_started        = 1'b0;
		own_id_reg          = '0;
		port_cnt_reg        = PCNT_W'(1);
		foreach (reach_tbl[i]) begin
			reach_tbl[i] = '0;
		end

		// A node that has not started yet starts on the first arrival.
		plan_req(CMD_ARRIVE, 6'd0, 3'd0);
		plan_typed(CMD_START, 6'd0, 3'd0, 1, make_result(1'b1, 3'd0, 6'd0, 1'b0, 1'b1));
		plan_typed(CMD_ARRIVE, 6'd0, 3'd0, 0, '0);
		plan_req(CMD_ARRIVE, 6'd63, 3'd7);
		plan_cfg(CFG_OWN_ID, 6'd63);
		plan_cfg(CFG_PORT_COUNT, 6'd8);
		plan_req(CMD_START, 6'd0, 3'd0);
		plan_req(CMD_ARRIVE, 6'd5, 3'd3);
		plan_typed(CMD_ARRIVE, 6'd63, 3'd0, 0, '0);
		plan_cfg(CFG_PORT_COUNT, 6'd15);
		plan_cfg(CFG_OWN_ID, 6'd42);
		plan_req(CMD_ARRIVE, 6'd42, 3'd2);
		plan_req(CMD_START, 6'd0, 3'd0);
		plan_req(CMD_ARRIVE, 6'd21, 3'd7);
		plan_cfg(CFG_PORT_COUNT, 6'd0);
		plan_typed(CMD_START, 6'd0, 3'd0, 0, '0);
		plan_typed(CMD_ARRIVE, 6'd10, 3'd7, 0, '0);
		plan_cfg(CFG_PORT_COUNT, 6'd2);
		plan_cfg(CFG_OWN_ID, 6'd1);
		// An arrival port beyond the port count is still the parent.
		plan_req(CMD_ARRIVE, 6'd1, 3'd5);
		plan_typed(CMD_ARRIVE, 6'd1, 3'd6, 1, make_result(1'b1, 3'd5, 6'd1, 1'b0, 1'b1));
		plan_req(CMD_START, 6'd0, 3'd0);
		plan_req(CMD_ARRIVE, 6'd2, 3'd0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			case (directed_rows[r].kind)
				ROW_CFG: begin
					wait_quiet();
					write_reg(directed_rows[r].sel, directed_rows[r].val);
				end
				ROW_TYPED: begin
					push_request(directed_rows[r].cmd, directed_rows[r].id, directed_rows[r].ap,
						1'b1, directed_rows[r].typed_count, directed_rows[r].typed_res);
				end
				default: begin
					push_request(directed_rows[r].cmd, directed_rows[r].id, directed_rows[r].ap,
						1'b0, 0, '0);
				end
			endcase
		end

		for (int ph = 0; ph < 9; ph++) begin
			wait_quiet();
			base = (ph * 7) % 58;
			if (ph % 2 == 1) begin
				write_reg(CFG_OWN_ID, CFG_DATA_W'(base + $urandom_range(0, 5)));
			end else begin
				write_reg(CFG_OWN_ID, CFG_DATA_W'($urandom_range(0, 63)));
			end
			write_reg(CFG_PORT_COUNT, CFG_DATA_W'(PHASE_PC[ph]));
			p = ports_in_use();
			calm = (ph % 3 == 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				pick = $urandom_range(0, 99);
				cmd = (pick < 6) ? CMD_START : CMD_ARRIVE;
				if (pick < 16) begin
					id = ID_W'($urandom_range(0, 63));
				end else begin
					id = ID_W'(base + $urandom_range(0, 5));
				end
				if (p > 0 && $urandom_range(0, 3) != 0) begin
					ap = PORT_W'($urandom_range(0, p - 1));
				end else begin
					ap = PORT_W'($urandom_range(0, 7));
				end
				if (!calm) begin
					sender_gap();
				end
				push_request(cmd, id, ap, 1'b0, 0, '0);
			end
		end

		wait_quiet();
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("flood_echo_node_handler: match");
		end else begin
			$display("flood_echo_node_handler: mismatch");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/fen_pkg.sv
rtl/core/fen_if.sv
rtl/core/fen_ram.sv
rtl/core/fen_front.sv
rtl/core/fen_queue.sv
rtl/core/fen_back.sv
rtl/core/flood_echo_node_handler.sv
rtl/core/fen_checker.sv
tb/tb_top.sv
